FILE: rtl/jei_pkg.sv
// Package for the Julia escape-time unit: widths, shared types and helpers.
// Used by every module of the block; depends on nothing.
package jei_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int WORD_W     = 32;
   localparam int COUNT_W    = 11;
   localparam int MAX_ITER   = 1024;
   localparam int MAG_W      = 14;
   localparam int DEN_W      = 37;
   localparam int REM_W      = DEN_W + 1;
   localparam int QUO_W      = 35;
   localparam int DIV_STEPS  = MAG_W + 17 + FRAC_BITS;
   localparam int STEP_W     = $clog2(DIV_STEPS + 1);
   localparam int WIDE_W     = 42;
   localparam int CSR_IDX_W  = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_RE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_IM   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CONST_RE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CONST_IM = 3'd7;

   typedef struct packed {
      logic [COUNT_W-1:0]       iteration_limit;
      logic [12:0]              image_width;
      logic [12:0]              image_height;
      logic [23:0]              zoom_factor;
      logic signed [WORD_W-1:0] offset_real;
      logic signed [WORD_W-1:0] offset_imag;
      logic signed [WORD_W-1:0] const_real;
      logic signed [WORD_W-1:0] const_imag;
   } cfg_type;

   // Start point handed from the mapping front to the iteration back end.
   typedef struct packed {
      logic signed [WORD_W-1:0] z_real;
      logic signed [WORD_W-1:0] z_imag;
   } start_type;

   // Saturate a wide signed value to the 32-bit word bounds.
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'($signed({1'b0, {(WORD_W-1){1'b1}}}));
      lo = -hi - WIDE_W'(1);
      if (v > hi) begin
         sat_word = hi[WORD_W-1:0];
      end else if (v < lo) begin
         sat_word = lo[WORD_W-1:0];
      end else begin
         sat_word = v[WORD_W-1:0];
      end
   endfunction

endpackage

FILE: rtl/jei_front.sv
// Front of the Julia escape-time unit: takes pixel beats and maps them to start
// points with two bit-serial dividers. Depends on jei_pkg.
module jei_front (
   input  logic              clock,
   input  logic              reset,
   input  jei_pkg::cfg_type  cfg,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,
   output logic              push,
   output jei_pkg::start_type push_data,
   input  logic              full
);
   import jei_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type          state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [MAG_W-1:0]         mag_ff[2], mag_in[2];
   logic                     neg_ff[2], neg_in[2];
   logic [DEN_W-1:0]         den_ff[2], den_in[2];
   logic [REM_W-1:0]         rem_ff[2], rem_in[2];
   logic [QUO_W-1:0]         quo_ff[2], quo_in[2];
   logic                     ovf_ff[2], ovf_in[2];
   logic signed [WORD_W-1:0] start_q[2];

   logic [11:0]              pix[2];
   logic [12:0]              size[2];
   logic signed [WORD_W-1:0] off[2];

   assign pix[0]  = req_tdata[11:0];
   assign pix[1]  = req_tdata[23:12];
   assign size[0] = cfg.image_width;
   assign size[1] = cfg.image_height;
   assign off[0]  = cfg.offset_real;
   assign off[1]  = cfg.offset_imag;

   assign req_tready = (state_ff == F_IDLE);
   assign push       = (state_ff == F_PUSH) && !full;
   assign push_data  = '{z_real: start_q[0], z_imag: start_q[1]};

   // Final quotient is capped, signed, offset and saturated per lane.
   always_comb begin
      logic [QUO_W-1:0]       capq;
      logic signed [WIDE_W-1:0] sq;
      for (int l = 0; l < 2; l++) begin
         capq = (ovf_ff[l] || quo_ff[l] > (QUO_W'(1) << (QUO_W-1)))
                ? (QUO_W'(1) << (QUO_W-1)) : quo_ff[l];
         sq = $signed(WIDE_W'(capq));
         if (neg_ff[l]) begin
            sq = -sq;
         end
         start_q[l] = sat_word(sq + WIDE_W'(off[l]));
      end
   end

   // Sequencer and restoring division, one quotient bit a cycle in each lane.
   always_comb begin
      logic signed [15:0] n;
      logic [23:0]        zoom;
      logic [12:0]        sz;
      logic [REM_W-1:0]   r2;
      n        = '0;
      zoom     = '0;
      sz       = '0;
      r2       = '0;
      state_in = state_ff;
      step_in  = step_ff;
      for (int l = 0; l < 2; l++) begin
         mag_in[l] = mag_ff[l];
         neg_in[l] = neg_ff[l];
         den_in[l] = den_ff[l];
         rem_in[l] = rem_ff[l];
         quo_in[l] = quo_ff[l];
         ovf_in[l] = ovf_ff[l];
      end
      unique case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               for (int l = 0; l < 2; l++) begin
                  n = $signed({3'b0, pix[l], 1'b0}) - $signed({3'b0, size[l]});
                  neg_in[l] = n[15];
                  mag_in[l] = n[15] ? MAG_W'(-n) : MAG_W'(n);
                  zoom = (cfg.zoom_factor == '0) ? 24'd1 : cfg.zoom_factor;
                  sz   = (size[l] == '0) ? 13'd1 : size[l];
                  den_in[l] = DEN_W'(zoom) * DEN_W'(sz);
                  rem_in[l] = '0;
                  quo_in[l] = '0;
                  ovf_in[l] = 1'b0;
               end
               step_in  = '0;
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            for (int l = 0; l < 2; l++) begin
               r2 = {rem_ff[l][REM_W-2:0], mag_ff[l][MAG_W-1]};
               mag_in[l] = {mag_ff[l][MAG_W-2:0], 1'b0};
               ovf_in[l] = ovf_ff[l] | quo_ff[l][QUO_W-1];
               if (r2 >= REM_W'(den_ff[l])) begin
                  rem_in[l] = r2 - REM_W'(den_ff[l]);
                  quo_in[l] = {quo_ff[l][QUO_W-2:0], 1'b1};
               end else begin
                  rem_in[l] = r2;
                  quo_in[l] = {quo_ff[l][QUO_W-2:0], 1'b0};
               end
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      for (int l = 0; l < 2; l++) begin
         mag_ff[l] <= mag_in[l];
         neg_ff[l] <= neg_in[l];
         den_ff[l] <= den_in[l];
         rem_ff[l] <= rem_in[l];
         quo_ff[l] <= quo_in[l];
         ovf_ff[l] <= ovf_in[l];
      end
   end

endmodule

FILE: rtl/jei_queue.sv
// Two-entry queue of start points between the front and the back end.
// Depends on jei_pkg.
module jei_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jei_pkg::start_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output jei_pkg::start_type pop_data
);
   import jei_pkg::*;

   start_type   mem_ff[2];
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/jei_back.sv
// Back end of the Julia escape-time unit: iterates z = z^2 + c on one start
// point at a time and holds the result beat. Depends on jei_pkg.
module jei_back (
   input  logic               clock,
   input  logic               reset,
   input  jei_pkg::cfg_type   cfg,
   input  logic               not_empty,
   input  jei_pkg::start_type pop_data,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,
   output logic               rsp_tuser
);
   import jei_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_MUL  = 4'b0010,
      B_UPD  = 4'b0100,
      B_OUT  = 4'b1000
   } back_state_type;

   back_state_type           state_ff, state_in;
   logic signed [WORD_W-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [63:0]       rr_ff, ii_ff, ri_ff;
   logic [COUNT_W-1:0]       cnt_ff, cnt_in;
   logic                     inside_ff, inside_in;
   logic                     vld_ff, vld_in;
   logic [COUNT_W-1:0]       res_cnt_ff, res_cnt_in;
   logic                     res_in_ff, res_in_in;
   logic [COUNT_W-1:0]       limit;
   logic [40:0]              mag;
   logic signed [WIDE_W-1:0] nr_wide, ni_wide;

   assign limit = (cfg.iteration_limit > COUNT_W'(MAX_ITER)) ? COUNT_W'(MAX_ITER)
                                                              : cfg.iteration_limit;
   assign pop        = (state_ff == B_IDLE) && not_empty;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {{(16-COUNT_W){1'b0}}, res_cnt_ff};
   assign rsp_tuser  = res_in_ff;

   // Magnitude test and next z from the registered products.
   assign mag     = 41'(rr_ff[63:FRAC_BITS]) + 41'(ii_ff[63:FRAC_BITS]);
   assign nr_wide = WIDE_W'((rr_ff - ii_ff) >>> FRAC_BITS) + WIDE_W'(cfg.const_real);
   assign ni_wide = WIDE_W'(ri_ff >>> (FRAC_BITS - 1)) + WIDE_W'(cfg.const_imag);

   // Iteration sequencer and output register.
   always_comb begin
      state_in   = state_ff;
      zr_in      = zr_ff;
      zi_in      = zi_ff;
      cnt_in     = cnt_ff;
      inside_in  = inside_ff;
      vld_in     = vld_ff && !rsp_tready;
      res_cnt_in = res_cnt_ff;
      res_in_in  = res_in_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (not_empty) begin
               zr_in    = pop_data.z_real;
               zi_in    = pop_data.z_imag;
               cnt_in   = '0;
               state_in = B_MUL;
            end
         end
         B_MUL: state_in = B_UPD;
         B_UPD: begin
            if (cnt_ff == limit) begin
               inside_in = 1'b1;
               state_in  = B_OUT;
            end else if (mag >= (41'd4 << FRAC_BITS)) begin
               inside_in = 1'b0;
               state_in  = B_OUT;
            end else begin
               zr_in    = sat_word(nr_wide);
               zi_in    = sat_word(ni_wide);
               cnt_in   = cnt_ff + COUNT_W'(1);
               state_in = B_MUL;
            end
         end
         B_OUT: begin
            if (!vld_ff || rsp_tready) begin
               vld_in     = 1'b1;
               res_cnt_in = cnt_ff;
               res_in_in  = inside_ff;
               state_in   = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
      zr_ff      <= zr_in;
      zi_ff      <= zi_in;
      cnt_ff     <= cnt_in;
      inside_ff  <= inside_in;
      res_cnt_ff <= res_cnt_in;
      res_in_ff  <= res_in_in;
      rr_ff      <= 64'(zr_ff) * 64'(zr_ff);
      ii_ff      <= 64'(zi_ff) * 64'(zi_ff);
      ri_ff      <= 64'(zr_ff) * 64'(zi_ff);
   end

endmodule

FILE: rtl/julia_escape_iteration_unit.sv
// Top level of the Julia escape-time unit: configuration registers, front,
// queue and back end. Depends on jei_pkg, jei_front, jei_queue and jei_back.
//
// Each pixel beat is mapped to a start point in signed Q8.24 by two serial
// dividers working side by side, then iterated by a unit with three 32x32
// multipliers that registers the products in B_MUL and updates z in B_UPD.
// The front maps the next pixel while the back end iterates; a two-entry
// queue sits between them. Configuration must be written only while no pixel
// is in flight; the user is bound by this, and nothing in the block enforces it.
module julia_escape_iteration_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [11:0] pixel_col, [23:12] pixel_row
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [10:0] escape_count, rest zero
   output logic        rsp_tuser,   // [0] inside_set
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import jei_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push, full, pop, not_empty;
   start_type push_data, pop_data;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LIMIT:    cfg_in.iteration_limit = csr_wdata[COUNT_W-1:0];
            CSR_WIDTH:    cfg_in.image_width     = csr_wdata[12:0];
            CSR_HEIGHT:   cfg_in.image_height    = csr_wdata[12:0];
            CSR_ZOOM:     cfg_in.zoom_factor     = csr_wdata[23:0];
            CSR_OFF_RE:   cfg_in.offset_real     = $signed(csr_wdata);
            CSR_OFF_IM:   cfg_in.offset_imag     = $signed(csr_wdata);
            CSR_CONST_RE: cfg_in.const_real      = $signed(csr_wdata);
            CSR_CONST_IM: cfg_in.const_imag      = $signed(csr_wdata);
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{iteration_limit: COUNT_W'(100), image_width: 13'd800,
                    image_height: 13'd800, zoom_factor: 24'd65536,
                    offset_real: '0, offset_imag: '0, const_real: '0, const_imag: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   jei_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .push(push), .push_data(push_data), .full(full)
   );

   jei_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data), .full(full),
      .pop(pop), .not_empty(not_empty), .pop_data(pop_data)
   );

   jei_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .not_empty(not_empty), .pop_data(pop_data), .pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Julia escape-time unit: pixel beats in, escape counts out.
// Depends on jei_pkg and julia_escape_iteration_unit; the expected counts come from a
// fixed-point predictor kept in this file.
module tb_top;
   import jei_pkg::*;

   localparam int  TIMEOUT_CYCLES = 4000000;
   localparam int  MISMATCH_SHOWN = 10;

   typedef struct {
      logic [COUNT_W-1:0] escape_count;
      logic               inside_set;
   } escape_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   // Shadow of the configuration registers, used by the predictor.
   cfg_type           shadow_cfg;
   escape_result_type pending_escapes[$];
   int                send_idle_pct;
   int                rsp_stall_pct;
   int                mismatch_count;
   int                pixels_sent;
   int                results_seen;
   int                inside_seen;
   longint            cycle_count;

   julia_escape_iteration_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [11:0] pixel_col, [23:12] pixel_row
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [10:0] escape_count, rest zero
      .rsp_tuser  (rsp_tuser),   // [0] inside_set
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Map one pixel coordinate to a start component, saturated to the word.
   function automatic logic signed [31:0] start_coord(input int unsigned p,
                                                      input int unsigned size,
                                                      input logic signed [31:0] off);
      longint            span;
      longint unsigned   span_mag;
      longint unsigned   denom;
      longint unsigned   quot;
      longint            signed_quot;
      longint            total;
      span     = 2 * longint'(p) - longint'(size);
      span_mag = (span < 0) ? -span : span;
      denom    = longint'(shadow_cfg.zoom_factor == 0 ? 1 : shadow_cfg.zoom_factor)
               * longint'(size == 0 ? 1 : size);
      quot     = (span_mag << 41) / denom;
      if (quot > (64'd1 << 34)) begin
         quot = 64'd1 << 34;
      end
      signed_quot = (span < 0) ? -longint'(quot) : longint'(quot);
      total       = signed_quot + longint'(off);
      if (total > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (total < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return total[31:0];
   endfunction

   function automatic logic signed [31:0] clamp_word(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Escape-time iteration for one pixel under the shadow configuration.
   function automatic escape_result_type pixel_escape(input logic [11:0] col,
                                                      input logic [11:0] row);
      escape_result_type res;
      int unsigned     limit;
      int unsigned     iter;
      logic signed [31:0] zr;
      logic signed [31:0] zi;
      logic signed [31:0] next_re;
      longint          rr;
      longint          ii;
      longint          ri;
      longint unsigned mag;
      limit = (shadow_cfg.iteration_limit > MAX_ITER) ? MAX_ITER : shadow_cfg.iteration_limit;
      zr    = start_coord(col, shadow_cfg.image_width, shadow_cfg.offset_real);
      zi    = start_coord(row, shadow_cfg.image_height, shadow_cfg.offset_imag);
      iter  = 0;
      while (iter < limit) begin
         rr  = longint'(zr) * longint'(zr);
         ii  = longint'(zi) * longint'(zi);
         ri  = longint'(zr) * longint'(zi);
         mag = longint'(rr >>> FRAC_BITS) + longint'(ii >>> FRAC_BITS);
         if (mag >= (64'd4 << FRAC_BITS)) begin
            break;
         end
         next_re = clamp_word(((rr - ii) >>> FRAC_BITS) + longint'(shadow_cfg.const_real));
         zi      = clamp_word((ri >>> (FRAC_BITS - 1)) + longint'(shadow_cfg.const_imag));
         zr      = next_re;
         iter++;
      end
      res.escape_count = iter[COUNT_W-1:0];
      res.inside_set   = (iter == limit);
      return res;
   endfunction

   // Receiver back-pressure, changed at the falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Result checker: each accepted beat is compared with the oldest prediction.
   always @(posedge clock) begin
      escape_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_escapes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_SHOWN) begin
               $display("ERROR: unexpected result beat count=%0d inside=%0b",
                        rsp_tdata[10:0], rsp_tuser);
            end
         end else begin
            want = pending_escapes.pop_front();
            if (want.inside_set) begin
               inside_seen++;
            end
            if (rsp_tdata[10:0] !== want.escape_count || rsp_tuser !== want.inside_set
                || rsp_tdata[15:11] !== 5'd0) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_SHOWN) begin
                  $display("ERROR: result %0d expected count=%0d inside=%0b, got data=%h inside=%0b",
                           results_seen, want.escape_count, want.inside_set,
                           rsp_tdata, rsp_tuser);
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Send one pixel beat; called at a falling edge, returns at a falling edge with
   // tvalid still high so that back-to-back beats need no extra assignment.
   task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {row, col};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pending_escapes.push_back(pixel_escape(col, row));
      pixels_sent++;
      @(negedge clock);
   endtask

   // Drop tvalid and wait until every predicted result has arrived.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_escapes.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_LIMIT:    shadow_cfg.iteration_limit = value[10:0];
         CSR_WIDTH:    shadow_cfg.image_width     = value[12:0];
         CSR_HEIGHT:   shadow_cfg.image_height    = value[12:0];
         CSR_ZOOM:     shadow_cfg.zoom_factor     = value[23:0];
         CSR_OFF_RE:   shadow_cfg.offset_real     = value;
         CSR_OFF_IM:   shadow_cfg.offset_imag     = value;
         CSR_CONST_RE: shadow_cfg.const_real      = value;
         default:      shadow_cfg.const_imag      = value;
      endcase
      @(negedge clock);
   endtask

   // Write a full configuration while the block is idle.
   task automatic load_config(input int unsigned limit, input int unsigned width,
                              input int unsigned height, input int unsigned zoom,
                              input logic [31:0] off_re, input logic [31:0] off_im,
                              input logic [31:0] c_re, input logic [31:0] c_im);
      drain_results();
      write_reg(CSR_LIMIT, limit);
      write_reg(CSR_WIDTH, width);
      write_reg(CSR_HEIGHT, height);
      write_reg(CSR_ZOOM, zoom);
      write_reg(CSR_OFF_RE, off_re);
      write_reg(CSR_OFF_IM, off_im);
      write_reg(CSR_CONST_RE, c_re);
      write_reg(CSR_CONST_IM, c_im);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Directed pixels: field extremes and each special case.
   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // Reset configuration, corners and centre.
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd400, 12'd400);
      send_pixel(12'd799, 12'd0);
      // A limit of zero gives no iteration at all.
      load_config(0, 800, 800, 65536, 0, 0, 0, 0);
      send_pixel(12'd100, 12'd700);
      // A limit above the maximum is clamped; the centre stays inside.
      load_config(2047, 800, 800, 65536, 0, 0, 0, 0);
      send_pixel(12'd400, 12'd400);
      load_config(1024, 800, 800, 65536, 32'h00400000, 0, 32'hff800000, 32'h00200000);
      send_pixel(12'd300, 12'd420);
      // Zero zoom and zero sizes are read as one; huge quotients saturate.
      load_config(20, 0, 0, 0, 0, 0, 0, 0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd2048);
      load_config(20, 4096, 4096, 1, 32'h7fffffff, 32'h80000000, 0, 0);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd2048, 12'd2048);
      // Largest sizes and zoom, constants at both word bounds.
      load_config(1, 8191, 8191, 24'hffffff, 32'h80000000, 32'h7fffffff,
                  32'h7fffffff, 32'h80000000);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd1, 12'd4094);
      load_config(50, 640, 480, 98304, 32'hfe000000, 32'h01000000,
                  32'hff34bc6a, 32'h00271de6);
      send_pixel(12'd320, 12'd240);
      send_pixel(12'd639, 12'd479);
      send_pixel(12'd2730, 12'd1365);
   endtask

   // Random configuration, mostly in the range where pixels iterate for a while.
   task automatic random_config(input int unsigned max_limit);
      logic [31:0] off_re;
      logic [31:0] off_im;
      logic [31:0] c_re;
      logic [31:0] c_im;
      int unsigned limit;
      int unsigned zoom;
      limit  = $urandom_range(1, max_limit);
      zoom   = ($urandom_range(9) == 0) ? $urandom_range(1, 24'hffffff)
                                        : $urandom_range(1 << 14, 1 << 18);
      off_re = ($urandom_range(9) == 0) ? $urandom()
                                        : 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      off_im = ($urandom_range(9) == 0) ? $urandom()
                                        : 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      c_re   = ($urandom_range(9) == 0) ? $urandom()
                                        : 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      c_im   = ($urandom_range(9) == 0) ? $urandom()
                                        : 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      load_config(limit, $urandom_range(1, 4096), $urandom_range(1, 4096), zoom,
                  off_re, off_im, c_re, c_im);
   endtask

   // A run of random pixels, mostly inside the configured image.
   task automatic random_pixels(input int count);
      logic [11:0] col;
      logic [11:0] row;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(4) == 0) begin
            col = 12'($urandom());
            row = 12'($urandom());
         end else begin
            col = 12'($urandom_range(0, shadow_cfg.image_width - 1));
            row = 12'($urandom_range(0, shadow_cfg.image_height - 1));
         end
         send_pixel(col, row);
      end
   endtask

   // Random phases under each idling pattern, several configurations each.
   task automatic test_random(input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int set = 0; set < 6; set++) begin
         random_config(48);
         random_pixels(62);
         if (set == 2) begin
            // Let the block run dry mid-phase before carrying on.
            drain_results();
            random_pixels(10);
         end
      end
   endtask

   // A few pixels with long iteration limits.
   task automatic test_long_limits();
      send_idle_pct = 9;
      rsp_stall_pct = 9;
      random_config(1024);
      random_pixels(10);
      load_config(1024, 64, 64, 65536, 0, 0, 32'hff5c28f6, 32'h00000000);
      random_pixels(10);
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_LIMIT;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      mismatch_count = 0;
      pixels_sent    = 0;
      results_seen   = 0;
      inside_seen    = 0;
      cycle_count    = 0;
      shadow_cfg     = '{iteration_limit: 100, image_width: 800, image_height: 800,
                         zoom_factor: 65536, offset_real: 0, offset_imag: 0,
                         const_real: 0, const_imag: 0};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random(0, 0);
      test_random(52, 0);
      test_random(0, 52);
      test_random(52, 52);
      test_random(9, 9);
      test_long_limits();

      drain_results();
      repeat (300) @(posedge clock);
      $display("Covered %0d pixels and %0d results (%0d inside the set) over many settings,",
               pixels_sent, results_seen, inside_seen);
      $display("with idle and stall patterns on both sides; %0d mismatches.", mismatch_count);
      if (mismatch_count == 0 && pending_escapes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
